/* sv/crc8pf_pkg.sv */
// Shared types, codes and the CRC byte update for the CRC-8 packet framer.
`timescale 1ns / 1ps
`default_nettype none
package crc8pf_pkg;

    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CRC_POLY      = 2'd2;

    localparam logic [7:0] CRC_POLY_RESET = 8'h07;

    localparam logic CMD_BEGIN   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  msg_type;
        logic [15:0] msg_len;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       frame_end;
    } t_beat;

    typedef enum logic [6:0] {
        PH_HDR1   = 7'b0000001,
        PH_HDR2   = 7'b0000010,
        PH_TYPE   = 7'b0000100,
        PH_LEN_LO = 7'b0001000,
        PH_LEN_HI = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_CRC    = 7'b1000000
    } t_phase;

    // One byte through the CRC register, MSB first, no augmentation.
    function automatic logic [7:0] crc_push(input logic [7:0] crc,
                                            input logic [7:0] b,
                                            input logic [7:0] poly);
        logic [7:0] c;
        logic       top;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            top = c[7];
            c   = {c[6:0], b[k]};
            if (top) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/crc8pf_in_reg.sv */
// Input register: holds one accepted item until the sequencer retires it.
`timescale 1ns / 1ps
`default_nettype none
module crc8pf_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  crc8pf_pkg::t_item   i_item,
    input  wire                 i_done,
    output logic                o_item_valid,
    output crc8pf_pkg::t_item   o_item
);
    import crc8pf_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready      = !r_valid || i_done;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

/* sv/crc8pf_seq.sv */
// Frame sequencer: walks one item through its output bytes and keeps the CRC.
`timescale 1ns / 1ps
`default_nettype none
module crc8pf_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_item_valid,
    input  crc8pf_pkg::t_item   i_item,
    input  wire [7:0]           i_header_first,
    input  wire [7:0]           i_header_second,
    input  wire [7:0]           i_crc_poly,
    input  wire                 i_out_free,
    output crc8pf_pkg::t_beat   o_beat,
    output logic                o_done
);
    import crc8pf_pkg::*;

    logic        r_mid;
    t_phase      r_phase;
    logic        r_frame_open;
    logic [15:0] r_bytes_left;
    logic [7:0]  r_crc;

    logic        n_mid;
    t_phase      n_phase;
    logic        n_frame_open;
    logic [15:0] n_bytes_left;
    logic [7:0]  n_crc;

    t_phase      cur_phase;
    logic        drop;
    logic        step;
    logic        last;
    logic [7:0]  crc_in;
    logic [7:0]  crc_byte;
    logic [7:0]  crc_next;

    // First beat of a fresh item picks its phase from the command.
    assign cur_phase = r_mid ? r_phase
                     : ((i_item.cmd == CMD_BEGIN) ? PH_HDR1 : PH_DATA);

    // Payload with no frame open retires without a beat.
    assign drop = (cur_phase == PH_DATA) && !r_frame_open;
    assign step = i_item_valid && (drop || i_out_free);

    assign crc_next = crc_push(crc_in, crc_byte, i_crc_poly);

    always_comb begin
        n_mid        = r_mid;
        n_phase      = r_phase;
        n_frame_open = r_frame_open;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        last         = 1'b0;
        crc_in       = r_crc;
        crc_byte     = i_item.data_byte;
        o_beat       = '0;

        case (cur_phase)
            PH_HDR1: begin
                o_beat.out_byte = i_header_first;
                n_phase         = PH_HDR2;
            end
            PH_HDR2: begin
                o_beat.out_byte = i_header_second;
                n_phase         = PH_TYPE;
            end
            PH_TYPE: begin
                o_beat.out_byte = i_item.msg_type;
                crc_in          = 8'h00;
                crc_byte        = i_item.msg_type;
                n_crc           = crc_next;
                n_phase         = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                o_beat.out_byte = i_item.msg_len[7:0];
                crc_byte        = i_item.msg_len[7:0];
                n_crc           = crc_next;
                n_phase         = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                o_beat.out_byte = i_item.msg_len[15:8];
                crc_byte        = i_item.msg_len[15:8];
                n_crc           = crc_next;
                n_bytes_left    = i_item.msg_len;
                n_frame_open    = (i_item.msg_len != 16'd0);
                n_phase         = PH_CRC;
                last            = (i_item.msg_len != 16'd0);
            end
            PH_DATA: begin
                o_beat.out_byte = i_item.data_byte;
                if (drop) begin
                    last = 1'b1;
                end else begin
                    n_crc        = crc_next;
                    n_bytes_left = r_bytes_left - 16'd1;
                    n_phase      = PH_CRC;
                    last         = (r_bytes_left != 16'd1);
                end
            end
            PH_CRC: begin
                o_beat.out_byte  = r_crc;
                o_beat.frame_end = 1'b1;
                n_frame_open     = 1'b0;
                last             = 1'b1;
            end
            default: begin
                last = 1'b1;
            end
        endcase

        o_beat.valid = step && !drop;
        n_mid        = !last;
    end

    assign o_done = step && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid        <= 1'b0;
            r_phase      <= PH_HDR1;
            r_frame_open <= 1'b0;
            r_bytes_left <= 16'd0;
            r_crc        <= 8'h00;
        end else if (step) begin
            r_mid        <= n_mid;
            r_phase      <= n_phase;
            r_frame_open <= n_frame_open;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
        end
    end

endmodule
`default_nettype wire

/* sv/crc8pf_out_reg.sv */
// Output register: one byte beat held until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none
module crc8pf_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  crc8pf_pkg::t_beat   i_beat,
    output logic                o_free,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_frame_end
);
    import crc8pf_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;

    assign o_free      = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_beat.valid) begin
            r_byte <= i_beat.out_byte;
            r_end  <= i_beat.frame_end;
        end
    end

endmodule
`default_nettype wire

/* sv/crc8_packet_framer_top.sv */
// Top level of the CRC-8 packet framer: config registers and the beat pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Builds framed packets as a byte stream. A begin item (cmd 0) yields the two
// configured header bytes, the message type and the payload length low byte
// first, then opens a frame; with a zero length the CRC byte follows at once.
// Each payload item (cmd 1) is passed through; the last one of the frame is
// followed by the CRC byte with frame_end high. The CRC-8 starts at zero,
// covers type, length and payload, MSB first, with the configured polynomial.
// Payload items with no frame open are dropped; a begin abandons an open
// frame without a CRC. Timing: one output beat per cycle while the sink is
// ready; the rate is set by the single byte-wide output register, and the
// sequencer emits at most one beat per clock. Payload bytes therefore stream
// back to back; the input register accepts the next item in the same cycle
// the current one retires. While the sink stalls, the output register holds
// its beat and the sequencer waits until the register is free.
// Config writes (index 0 header_first, 1 header_second, 2 crc_poly; other
// indexes ignored) are meant for idle periods only.
module crc8_packet_framer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_cmd,
    input  wire  [7:0]  i_msg_type,
    input  wire  [15:0] i_msg_len,
    input  wire  [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    input  wire         i_cfg_we,
    input  wire  [crc8pf_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    import crc8pf_pkg::*;

    // Configuration registers.
    logic [7:0] r_header_first;
    logic [7:0] r_header_second;
    logic [7:0] r_crc_poly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= 8'h00;
            r_header_second <= 8'h00;
            r_crc_poly      <= CRC_POLY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                CFG_CRC_POLY:      r_crc_poly      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    t_item in_item;
    t_item cur_item;
    logic  item_valid;
    logic  item_done;
    t_beat beat;
    logic  out_free;

    assign in_item.cmd       = i_cmd;
    assign in_item.msg_type  = i_msg_type;
    assign in_item.msg_len   = i_msg_len;
    assign in_item.data_byte = i_data_byte;

    // Input beat register: refills in the cycle its item retires.
    crc8pf_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (in_item),
        .i_done       (item_done),
        .o_item_valid (item_valid),
        .o_item       (cur_item)
    );

    // Sequencer: header, length, payload and CRC beats plus frame state.
    crc8pf_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .i_item          (cur_item),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .i_crc_poly      (r_crc_poly),
        .i_out_free      (out_free),
        .o_beat          (beat),
        .o_done          (item_done)
    );

    // Output beat register toward the sink.
    crc8pf_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule
`default_nettype wire

/* dv/crc8_frame_checker.sv */
// Checker for the CRC-8 packet framer: predicts the output byte stream and compares beats.
`timescale 1ns / 1ps
module crc8_frame_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire               i_cmd,
    input  wire  [7:0]        i_msg_type,
    input  wire  [15:0]       i_msg_len,
    input  wire  [7:0]        i_data_byte,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  wire  [7:0]        i_out_byte,
    input  wire               i_frame_end,
    input  wire               i_cfg_we,
    input  wire  [crc8pf_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire  [7:0]        i_cfg_data,
    output int                o_mismatches,
    output int                o_beats_due
);
    import crc8pf_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    t_frame_byte frame_bytes_due[$];

    // Mirror of the config registers and the framing state.
    logic [7:0]  hdr_a;
    logic [7:0]  hdr_b;
    logic [7:0]  gen_poly;
    logic        in_frame;
    logic [15:0] remaining;
    logic [7:0]  running_crc;

    initial begin
        o_mismatches = 0;
        o_beats_due  = 0;
    end

    // Shift one byte into the CRC, MSB first; feedback whenever the bit shifted out of bit 7 is set.
    function automatic logic [7:0] crc8_fold_byte(input logic [7:0] acc,
                                                  input logic [7:0] din,
                                                  input logic [7:0] gen);
        logic [7:0] r;
        logic       msb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            msb = r[7];
            r   = {r[6:0], din[i]} ^ (msb ? gen : 8'h00);
        end
        return r;
    endfunction

    function automatic t_frame_byte mk(input logic [7:0] v, input logic e);
        t_frame_byte fb;
        fb.value = v;
        fb.last  = e;
        return fb;
    endfunction

    task automatic frame_predict(input logic c, input logic [7:0] t,
                                 input logic [15:0] l, input logic [7:0] d);
        if (c == CMD_BEGIN) begin
            frame_bytes_due.push_back(mk(hdr_a, 1'b0));
            frame_bytes_due.push_back(mk(hdr_b, 1'b0));
            frame_bytes_due.push_back(mk(t, 1'b0));
            frame_bytes_due.push_back(mk(l[7:0], 1'b0));
            frame_bytes_due.push_back(mk(l[15:8], 1'b0));
            running_crc = crc8_fold_byte(8'h00, t, gen_poly);
            running_crc = crc8_fold_byte(running_crc, l[7:0], gen_poly);
            running_crc = crc8_fold_byte(running_crc, l[15:8], gen_poly);
            remaining   = l;
            in_frame    = (l != 16'd0);
            if (l == 16'd0) begin
                frame_bytes_due.push_back(mk(running_crc, 1'b1));
            end
        end else if (in_frame) begin
            frame_bytes_due.push_back(mk(d, 1'b0));
            running_crc = crc8_fold_byte(running_crc, d, gen_poly);
            remaining   = remaining - 16'd1;
            if (remaining == 16'd0) begin
                frame_bytes_due.push_back(mk(running_crc, 1'b1));
                in_frame = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_byte want;
        if (!i_rst_n) begin
            hdr_a       = 8'h00;
            hdr_b       = 8'h00;
            gen_poly    = CRC_POLY_RESET;
            in_frame    = 1'b0;
            remaining   = 16'd0;
            running_crc = 8'h00;
            frame_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEADER_FIRST:  hdr_a    = i_cfg_data;
                    CFG_HEADER_SECOND: hdr_b    = i_cfg_data;
                    CFG_CRC_POLY:      gen_poly = i_cfg_data;
                    default: ;
                endcase
            end
            // Output side first: a beat leaving now cannot belong to an item taken now.
            if (i_out_valid && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, %s %02h frame_end %0b",
                             $time, "got out_byte", i_out_byte, i_frame_end);
                    o_mismatches++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (i_out_byte !== want.value) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.value, i_out_byte);
                        o_mismatches++;
                    end
                    if (i_frame_end !== want.last) begin
                        $display("%0t: frame_end expected %0b, got %0b",
                                 $time, want.last, i_frame_end);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                frame_predict(i_cmd, i_msg_type, i_msg_len, i_data_byte);
            end
        end
        o_beats_due = frame_bytes_due.size();
    end

endmodule

/* dv/testbench.sv */
// Testbench top for the CRC-8 packet framer: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module testbench;
    import crc8pf_pkg::*;

    // Index 3 decodes to no register; writes there must leave everything alone.
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    wire                in_ready;
    logic               cmd;
    logic [7:0]         msg_type;
    logic [15:0]        msg_len;
    logic [7:0]         data_byte;
    wire                out_valid;
    logic               out_ready;
    wire  [7:0]         out_byte;
    wire                frame_end;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [7:0]         cfg_data;

    int mismatches;
    int beats_due;
    int items_sent;
    int idle_pct;    // chance per cycle that the sender holds back
    int stall_pct;   // chance per cycle that the sink deasserts ready

    crc8_packet_framer_top DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_cmd            (cmd),
        .i_msg_type       (msg_type),
        .i_msg_len        (msg_len),
        .i_data_byte      (data_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_byte       (out_byte),
        .o_frame_end      (frame_end),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    crc8_frame_checker frame_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_cmd            (cmd),
        .i_msg_type       (msg_type),
        .i_msg_len        (msg_len),
        .i_data_byte      (data_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_byte       (out_byte),
        .i_frame_end      (frame_end),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatches     (mismatches),
        .o_beats_due      (beats_due)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run here.
    initial begin
        #10_000_000;
        $display("crc8_packet_framer_top: mismatch");
        $finish;
    end

    // Sink side: ready is redrawn every falling edge; stall_pct 0 means always ready.
    always @(negedge clk) begin
        out_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    // Present one item and hold it until the beat is taken. Valid stays high
    // afterwards so back-to-back items run with no bubble; it only drops for
    // an idle gap, a register write or the end of the run.
    task automatic offer(input logic c, input logic [7:0] t,
                         input logic [15:0] l, input logic [7:0] d);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd       = c;
        msg_type  = t;
        msg_len   = l;
        data_byte = d;
        in_valid  = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Begin beats carry junk in data_byte, payload beats junk in type/length:
    // the block must ignore the unused fields.
    task automatic open_frame(input logic [7:0] t, input logic [15:0] l);
        offer(CMD_BEGIN, t, l, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_payload(input logic [7:0] d);
        offer(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), d);
    endtask

    // Registers change only with the block drained. A dropped payload yields
    // no beat, so after the queue empties we still let the pipe settle before writing.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
        in_valid = 1'b0;
        while (beats_due != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Mostly complete frames with random content, plus abandoned frames
    // (any nonzero 16-bit length, cut short by the next begin) and stray payloads.
    task automatic random_traffic(input int n_items);
        int stop;
        int len;
        int r;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30)
                                                  : $urandom_range(0, 6);
                open_frame(8'($urandom_range(0, 255)), 16'(len));
                repeat (len) push_payload(8'($urandom_range(0, 255)));
            end else if (r < 90) begin
                len = $urandom_range(1, 65535);
                open_frame(8'($urandom_range(0, 255)), 16'(len));
                repeat ($urandom_range(0, (len < 4) ? len - 1 : 3))
                    push_payload(8'($urandom_range(0, 255)));
            end else begin
                push_payload(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_BEGIN;
        msg_type   = 8'h00;
        msg_len    = 16'h0000;
        data_byte  = 8'h00;
        out_ready  = 1'b1;
        cfg_we     = 1'b0;
        cfg_index  = CFG_HEADER_FIRST;
        cfg_data   = 8'h00;
        items_sent = 0;
        idle_pct   = 0;
        stall_pct  = 0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset config (headers 00, poly 07), no idling.
        push_payload(8'hA5);                 // nothing open: dropped
        open_frame(8'h00, 16'h0000);         // zero length: CRC right after header
        open_frame(8'hFF, 16'h0001);
        push_payload(8'hFF);                 // single byte closes the frame
        open_frame(8'hA5, 16'h0002);
        push_payload(8'h00);
        push_payload(8'h80);
        open_frame(8'h5A, 16'hFFFF);         // max length, abandoned below
        push_payload(8'h01);
        open_frame(8'h3C, 16'h0100);         // begin over an open frame
        push_payload(8'h7F);
        open_frame(8'hC3, 16'h0003);
        push_payload(8'hFE);
        push_payload(8'h55);
        push_payload(8'hAA);
        push_payload(8'h12);                 // frame already closed: dropped

        // All-ones config, back-to-back traffic.
        write_reg(CFG_HEADER_FIRST, 8'hFF);
        write_reg(CFG_HEADER_SECOND, 8'hFF);
        write_reg(CFG_CRC_POLY, 8'hFF);
        random_traffic(100);

        // All-zero config (poly 0 degenerates to a plain shift), sender idling.
        write_reg(CFG_HEADER_FIRST, 8'h00);
        write_reg(CFG_HEADER_SECOND, 8'h00);
        write_reg(CFG_CRC_POLY, 8'h00);
        write_reg(CFG_UNUSED, 8'hFF);
        idle_pct = 77;
        random_traffic(100);

        // Random config, sink stalling.
        idle_pct = 0;
        write_reg(CFG_HEADER_FIRST, 8'($urandom_range(0, 255)));
        write_reg(CFG_HEADER_SECOND, 8'($urandom_range(0, 255)));
        write_reg(CFG_CRC_POLY, 8'($urandom_range(0, 255)));
        stall_pct = 77;
        random_traffic(100);

        // Standard poly again with random headers, light idling on both sides.
        write_reg(CFG_HEADER_FIRST, 8'($urandom_range(0, 255)));
        write_reg(CFG_HEADER_SECOND, 8'($urandom_range(0, 255)));
        write_reg(CFG_CRC_POLY, CRC_POLY_RESET);
        idle_pct  = 8;
        stall_pct = 8;
        random_traffic(100);

        // Drain, then let any stray beat show up before the verdict.
        in_valid = 1'b0;
        while (beats_due != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0) begin
            $display("crc8_packet_framer_top: match");
        end else begin
            $display("crc8_packet_framer_top: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/crc8pf_pkg.sv
sv/crc8pf_in_reg.sv
sv/crc8pf_seq.sv
sv/crc8pf_out_reg.sv
sv/crc8_packet_framer_top.sv
dv/crc8_frame_checker.sv
dv/testbench.sv
